@@ src/pbws_pkg.sv @@
// shared types and constants for the protobuf wire candidate scanner
`default_nettype none
package pbws_pkg;

   localparam int START_LANES_DEF      = 12;
   localparam int MAX_FIELDS_DEF       = 12;
   localparam int MAX_VARINT_BYTES_DEF = 10;
   localparam int MAX_PAYLOAD          = 65535;
   localparam int FIELD_LIMIT_RESET    = 4096;

   localparam int POS_W      = $clog2(MAX_PAYLOAD + 2);
   localparam int LANE_IDX_W = 5;
   localparam int FIELD_W    = 4;
   localparam int ACC_W      = 24;

   localparam logic [2:0] WIRE_VARINT = 3'd0;
   localparam logic [2:0] WIRE_FIXED64 = 3'd1;
   localparam logic [2:0] WIRE_LEN    = 3'd2;
   localparam logic [2:0] WIRE_SGROUP = 3'd3;
   localparam logic [2:0] WIRE_EGROUP = 3'd4;
   localparam logic [2:0] WIRE_FIXED32 = 3'd5;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_byte;
   } pbws_req_type;

   typedef struct packed {
      logic        found;
      logic [3:0]  best_start;
      logic [3:0]  field_count;
      logic [15:0] consumed_bytes;
      logic        too_long;
   } pbws_rsp_type;

   // what travels from cell to cell on each advance
   typedef struct packed {
      logic                  valid;
      logic [7:0]            byte_value;
      logic                  last_byte;
      logic [POS_W-1:0]      pos;
      logic                  too_long;
      logic [FIELD_W-1:0]    best_f;
      logic [POS_W-1:0]      best_c;
      logic [LANE_IDX_W-1:0] best_s;
   } pbws_token_type;

endpackage
`default_nettype wire

@@ src/pbws_cell.sv @@
// one candidate parser lane of the scanner chain
`default_nettype none
module pbws_cell #(
   parameter int LANE             = 0,
   parameter int MAX_FIELDS       = pbws_pkg::MAX_FIELDS_DEF,
   parameter int MAX_VARINT_BYTES = pbws_pkg::MAX_VARINT_BYTES_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     advance,
   input  wire logic [15:0]              field_limit,
   input  wire pbws_pkg::pbws_token_type tok_in,
   output pbws_pkg::pbws_token_type      tok_out
);

   localparam int PW = pbws_pkg::POS_W;
   localparam int AW = pbws_pkg::ACC_W;
   localparam int FW = pbws_pkg::FIELD_W;

   typedef enum logic [2:0] {PH_WAIT, PH_KEY, PH_VALUE, PH_LEN, PH_SKIP} phase_type;

   phase_type         phase_ff, phase_in, ph_eff;
   logic [3:0]        vb_ff, vb_in, vb_eff, vb_nx;
   logic [AW-1:0]     acc_ff, acc_in, acc_eff, acc_nx;
   logic              over_ff, over_in, over_eff, over_nx;
   logic [PW-1:0]     skip_ff, skip_in, skip_dec;
   logic [FW-1:0]     fields_ff, fields_in;
   logic [PW-1:0]     end_ff, end_in;
   logic              stop_ff, stop_in;
   pbws_pkg::pbws_token_type tok_ff, tok_in_nx;

   logic              start, active, vend, vstop, bad, complete;
   logic [6:0]        d;
   logic [30:0]       shifted;
   logic [2:0]        wire_t;
   logic [20:0]       field_num;
   logic [PW-1:0]     len, cons;

   always_comb begin
      start   = (tok_in.pos == PW'(LANE));
      ph_eff  = phase_ff;
      vb_eff  = vb_ff;
      acc_eff = acc_ff;
      over_eff = over_ff;
      if (phase_ff == PH_WAIT) begin
         ph_eff   = PH_KEY;
         vb_eff   = '0;
         acc_eff  = '0;
         over_eff = 1'b0;
      end
      active = tok_in.valid && (tok_in.pos < PW'(pbws_pkg::MAX_PAYLOAD)) && !stop_ff &&
               ((phase_ff != PH_WAIT) || start);

      // varint byte accumulation, low 24 bits kept plus an overflow flag
      d = tok_in.byte_value[6:0];
      case (vb_eff[1:0])
         2'd0:    shifted = 31'(d);
         2'd1:    shifted = 31'(d) << 7;
         2'd2:    shifted = 31'(d) << 14;
         default: shifted = 31'(d) << 21;
      endcase
      acc_nx  = acc_eff;
      over_nx = over_eff;
      if (vb_eff <= 4'd3) begin
         acc_nx  = acc_eff | shifted[AW-1:0];
         over_nx = over_eff | (shifted[30:AW] != '0);
      end else if (vb_eff <= 4'd8) begin
         over_nx = over_eff | (d != '0);
      end else begin
         over_nx = over_eff | d[0];
      end
      vb_nx = vb_eff + 4'd1;
      vend  = !tok_in.byte_value[7];
      vstop = !vend && (vb_nx >= 4'(MAX_VARINT_BYTES));

      wire_t    = acc_nx[2:0];
      field_num = acc_nx[AW-1:3];
      bad = over_nx || (field_num == '0) || (field_num > {5'b0, field_limit}) ||
            (wire_t == pbws_pkg::WIRE_SGROUP) || (wire_t == pbws_pkg::WIRE_EGROUP) ||
            (wire_t > pbws_pkg::WIRE_FIXED32);
      if (over_nx || (acc_nx > AW'(pbws_pkg::MAX_PAYLOAD)))
         len = PW'(pbws_pkg::MAX_PAYLOAD + 1);
      else
         len = acc_nx[PW-1:0];
      skip_dec = (skip_ff != '0) ? skip_ff - PW'(1) : skip_ff;

      phase_in  = phase_ff;
      vb_in     = vb_ff;
      acc_in    = acc_ff;
      over_in   = over_ff;
      skip_in   = skip_ff;
      fields_in = fields_ff;
      end_in    = end_ff;
      stop_in   = stop_ff;
      complete  = 1'b0;

      if (active) begin
         phase_in = ph_eff;
         case (ph_eff)
            PH_KEY: begin
               vb_in = vb_nx; acc_in = acc_nx; over_in = over_nx;
               if (vstop) stop_in = 1'b1;
               if (vend) begin
                  if (bad) begin
                     stop_in = 1'b1;
                  end else begin
                     vb_in = '0; acc_in = '0; over_in = 1'b0;
                     if (wire_t == pbws_pkg::WIRE_VARINT) begin
                        phase_in = PH_VALUE;
                     end else if (wire_t == pbws_pkg::WIRE_LEN) begin
                        phase_in = PH_LEN;
                     end else begin
                        phase_in = PH_SKIP;
                        skip_in  = (wire_t == pbws_pkg::WIRE_FIXED64) ? PW'(8) : PW'(4);
                     end
                  end
               end
            end
            PH_VALUE: begin
               vb_in = vb_nx; acc_in = acc_nx; over_in = over_nx;
               if (vstop) stop_in = 1'b1;
               complete = vend;
            end
            PH_LEN: begin
               vb_in = vb_nx; acc_in = acc_nx; over_in = over_nx;
               if (vstop) stop_in = 1'b1;
               if (vend) begin
                  if (len == '0) begin
                     complete = 1'b1;
                  end else begin
                     skip_in  = len;
                     phase_in = PH_SKIP;
                  end
               end
            end
            PH_SKIP: begin
               skip_in  = skip_dec;
               complete = (skip_dec == '0);
            end
            default: stop_in = 1'b1;
         endcase
         if (complete) begin
            fields_in = fields_ff + FW'(1);
            end_in    = tok_in.pos + PW'(1);
            vb_in = '0; acc_in = '0; over_in = 1'b0;
            phase_in  = PH_KEY;
            if (fields_in >= FW'(MAX_FIELDS)) stop_in = 1'b1;
         end
      end

      // running best travels with the last byte
      cons = '0;
      if ((fields_in != '0) && (end_in >= PW'(LANE))) cons = end_in - PW'(LANE);
      tok_in_nx = tok_in;
      if (tok_in.valid && tok_in.last_byte &&
          ((fields_in > tok_in.best_f) ||
           ((fields_in == tok_in.best_f) && (cons > tok_in.best_c)))) begin
         tok_in_nx.best_f = fields_in;
         tok_in_nx.best_c = cons;
         tok_in_nx.best_s = pbws_pkg::LANE_IDX_W'(LANE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         vb_ff <= '0; acc_ff <= '0; over_ff <= 1'b0; skip_ff <= '0;
         fields_ff <= '0; end_ff <= '0; stop_ff <= 1'b0;
         tok_ff <= '0;
      end else if (advance) begin
         tok_ff <= tok_in_nx;
         if (tok_in.valid && tok_in.last_byte) begin
            phase_ff <= PH_WAIT;
            vb_ff <= '0; acc_ff <= '0; over_ff <= 1'b0; skip_ff <= '0;
            fields_ff <= '0; end_ff <= '0; stop_ff <= 1'b0;
         end else begin
            phase_ff <= phase_in;
            vb_ff <= vb_in; acc_ff <= acc_in; over_ff <= over_in; skip_ff <= skip_in;
            fields_ff <= fields_in; end_ff <= end_in; stop_ff <= stop_in;
         end
      end
   end

   assign tok_out = tok_ff;

endmodule
`default_nettype wire

@@ src/protobuf_wire_candidate_scanner_core.sv @@
// top level of the protobuf wire candidate scanner
`default_nettype none
// Scans a payload for protobuf wire-format fields, taking one byte per cycle
// on req. A row of START_LANES parser cells, one per start offset, each tries
// to parse from its own offset; a byte and its position hop one cell per cycle
// while the row advances. The byte flagged last_byte also carries the running
// best (field count, consumed bytes, offset) down the row, each cell folding in
// its own score and then clearing itself for the next payload, so payloads may
// follow back to back. The result is registered into the rsp slot when the last
// byte leaves the final cell. Throughput is one byte per cycle while rsp is
// taken; a held result stalls the whole row. Bytes past MAX_PAYLOAD are ignored
// and set too_long. The one csr register is the largest accepted field number;
// write it only while no payload is in flight.
module protobuf_wire_candidate_scanner_core #(
   parameter int START_LANES      = pbws_pkg::START_LANES_DEF,
   parameter int MAX_FIELDS       = pbws_pkg::MAX_FIELDS_DEF,
   parameter int MAX_VARINT_BYTES = pbws_pkg::MAX_VARINT_BYTES_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire pbws_pkg::pbws_req_type req_payload,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output pbws_pkg::pbws_rsp_type      rsp_payload,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [15:0]            csr_wdata
);

   localparam int PW = pbws_pkg::POS_W;

   logic                     advance;
   logic [PW-1:0]            pos_ff, pos_in;
   logic [15:0]              limit_ff;
   logic                     rsp_valid_ff;
   pbws_pkg::pbws_rsp_type   rsp_ff;
   pbws_pkg::pbws_token_type entry;
   pbws_pkg::pbws_token_type chain [START_LANES+1];
   pbws_pkg::pbws_token_type tail;

   // the row moves whenever the output slot is free or being emptied
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   // byte position saturates one past the bound
   always_comb begin
      pos_in = pos_ff;
      if (req_valid && req_ready) begin
         if (req_payload.last_byte)
            pos_in = '0;
         else if (pos_ff <= PW'(pbws_pkg::MAX_PAYLOAD))
            pos_in = pos_ff + PW'(1);
      end
      entry            = '0;
      entry.valid      = req_valid;
      entry.byte_value = req_payload.byte_value;
      entry.last_byte  = req_payload.last_byte;
      entry.pos        = pos_ff;
      entry.too_long   = (pos_ff >= PW'(pbws_pkg::MAX_PAYLOAD));
   end

   assign chain[0] = entry;

   for (genvar s = 0; s < START_LANES; s++) begin : g_lane
      pbws_cell #(
         .LANE             (s),
         .MAX_FIELDS       (MAX_FIELDS),
         .MAX_VARINT_BYTES (MAX_VARINT_BYTES)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .field_limit (limit_ff),
         .tok_in      (chain[s]),
         .tok_out     (chain[s+1])
      );
   end

   assign tail = chain[START_LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         limit_ff     <= 16'(pbws_pkg::FIELD_LIMIT_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         if (csr_valid && csr_ready) limit_ff <= csr_wdata;
         if (advance) rsp_valid_ff <= tail.valid && tail.last_byte;
      end
      // result slot payload
      if (advance && tail.valid && tail.last_byte) begin
         rsp_ff.found          <= (tail.best_f != '0);
         rsp_ff.best_start     <= tail.best_s[3:0];
         rsp_ff.field_count    <= tail.best_f;
         rsp_ff.consumed_bytes <= tail.best_c[15:0];
         rsp_ff.too_long       <= tail.too_long;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");
   a_found_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.found == (rsp_payload.field_count != 4'd0)))
      else $error("found disagrees with field count");
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.found) |->
      (rsp_payload.consumed_bytes == 16'd0 && rsp_payload.best_start == 4'd0))
      else $error("empty result not zeroed");
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input taken while result held");
`endif

endmodule
`default_nettype wire

@@ sim/tb.sv @@
// self-checking testbench for the protobuf wire candidate scanner
`default_nettype none
module tb;

   localparam int LANES      = pbws_pkg::START_LANES_DEF;
   localparam int FIELDS_CAP = pbws_pkg::MAX_FIELDS_DEF;
   localparam int VARINT_CAP = pbws_pkg::MAX_VARINT_BYTES_DEF;
   localparam int DRAIN_WAIT = LANES + 8;   // row depth plus margin
   localparam int QUIET_LIMIT = 4000;       // cycles with no transfer on any port

   typedef enum logic [2:0] {
      LANE_WAIT, LANE_KEY, LANE_VALUE, LANE_LEN, LANE_SKIP
   } lane_phase_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   pbws_pkg::pbws_req_type req_payload;
   logic                   rsp_valid;
   logic                   rsp_ready;
   pbws_pkg::pbws_rsp_type rsp_payload;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [15:0]            csr_wdata;

   protobuf_wire_candidate_scanner_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata)
   );

   // scanner state as the testbench sees it
   logic [15:0]    field_limit;
   logic [16:0]    scan_pos;
   lane_phase_type phase     [LANES];
   logic [3:0]     vbytes    [LANES];
   logic [23:0]    accum     [LANES];
   logic           accum_over[LANES];
   logic [2:0]     wire_kind [LANES];
   logic [16:0]    skip_left [LANES];
   logic [3:0]     fields    [LANES];
   logic [16:0]    good_end  [LANES];
   logic           stopped   [LANES];

   pbws_pkg::pbws_rsp_type expected_scans[$];
   int                     fail_count;
   int                     quiet_cycles;
   int                     cycle_count;

   // sender pacing
   bit            pacing_on;
   int            burst_left;

   always #2 clock = ~clock;

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      rsp_ready   = 1'b0;
      csr_valid   = 1'b0;
      csr_wdata   = '0;
   end

   // ---------------------------------------------------------------- prediction

   function automatic void clear_lanes();
      scan_pos = '0;
      for (int s = 0; s < LANES; s++) begin
         phase[s]      = LANE_WAIT;
         vbytes[s]     = '0;
         accum[s]      = '0;
         accum_over[s] = 1'b0;
         wire_kind[s]  = '0;
         skip_left[s]  = '0;
         fields[s]     = '0;
         good_end[s]   = '0;
         stopped[s]    = 1'b0;
      end
   endfunction

   function automatic void varint_restart(int s);
      vbytes[s]     = '0;
      accum[s]      = '0;
      accum_over[s] = 1'b0;
   endfunction

   // one varint byte into lane s, returns 1 when the varint is complete
   function automatic bit varint_take(int s, logic [7:0] b);
      logic [63:0] shifted;
      int          i;
      i = vbytes[s];
      if (i <= 3) begin
         shifted = 64'(b[6:0]) << (7 * i);
         accum[s] |= shifted[23:0];
         if (shifted[63:24] != '0) accum_over[s] = 1'b1;
      end else if (i <= 8) begin
         if (b[6:0] != '0) accum_over[s] = 1'b1;
      end else if (b[0]) begin
         // only bit 63 of a 64-bit value lives in the tenth byte
         accum_over[s] = 1'b1;
      end
      vbytes[s] = 4'(i + 1);
      if (!b[7]) return 1'b1;
      if (i + 1 >= VARINT_CAP) stopped[s] = 1'b1;
      return 1'b0;
   endfunction

   function automatic void field_done(int s, logic [16:0] pos);
      fields[s]   = fields[s] + 4'd1;
      good_end[s] = pos + 17'd1;
      varint_restart(s);
      phase[s] = LANE_KEY;
      if (fields[s] >= FIELDS_CAP) stopped[s] = 1'b1;
   endfunction

   function automatic void lane_advance(int s, logic [7:0] b, logic [16:0] pos);
      logic [23:0] key;
      logic [20:0] fnum;
      logic [16:0] len;
      if (stopped[s]) return;
      if (phase[s] == LANE_WAIT) begin
         if (pos != 17'(s)) return;
         phase[s] = LANE_KEY;
         varint_restart(s);
      end
      case (phase[s])
         LANE_KEY: begin
            if (varint_take(s, b)) begin
               key          = accum[s];
               fnum         = key[23:3];
               wire_kind[s] = key[2:0];
               if (accum_over[s] || fnum == '0 || fnum > 21'(field_limit) ||
                   key[2:0] == pbws_pkg::WIRE_SGROUP ||
                   key[2:0] == pbws_pkg::WIRE_EGROUP ||
                   key[2:0] > pbws_pkg::WIRE_FIXED32) begin
                  stopped[s] = 1'b1;
                  return;
               end
               varint_restart(s);
               if (key[2:0] == pbws_pkg::WIRE_VARINT) phase[s] = LANE_VALUE;
               else if (key[2:0] == pbws_pkg::WIRE_LEN) phase[s] = LANE_LEN;
               else begin
                  phase[s]     = LANE_SKIP;
                  skip_left[s] = (key[2:0] == pbws_pkg::WIRE_FIXED64) ? 17'd8 : 17'd4;
               end
            end
         end
         LANE_VALUE: begin
            if (varint_take(s, b)) field_done(s, pos);
         end
         LANE_LEN: begin
            if (varint_take(s, b)) begin
               // a length that can never fit holds the lane until the payload ends
               if (accum_over[s] || accum[s] > 24'(pbws_pkg::MAX_PAYLOAD))
                  len = 17'(pbws_pkg::MAX_PAYLOAD + 1);
               else
                  len = accum[s][16:0];
               if (len == '0) field_done(s, pos);
               else begin
                  skip_left[s] = len;
                  phase[s]     = LANE_SKIP;
               end
            end
         end
         LANE_SKIP: begin
            if (skip_left[s] > 0) skip_left[s] = skip_left[s] - 17'd1;
            if (skip_left[s] == 0) field_done(s, pos);
         end
         default: stopped[s] = 1'b1;
      endcase
   endfunction

   // applies one accepted byte; on the last byte queues the expected scan result
   function automatic void scan_byte(logic [7:0] b, logic last);
      logic [16:0]            pos;
      int                     best_s, best_f, best_c, f, c;
      pbws_pkg::pbws_rsp_type res;
      pos = scan_pos;
      if (pos < 17'(pbws_pkg::MAX_PAYLOAD))
         for (int s = 0; s < LANES; s++) lane_advance(s, b, pos);
      if (pos <= 17'(pbws_pkg::MAX_PAYLOAD)) scan_pos = pos + 17'd1;
      if (!last) return;
      best_s = 0;
      best_f = 0;
      best_c = 0;
      for (int s = 0; s < LANES; s++) begin
         f = fields[s];
         c = 0;
         if (f > 0 && good_end[s] >= 17'(s)) c = good_end[s] - s;
         if (f > best_f || (f == best_f && c > best_c)) begin
            best_s = s;
            best_f = f;
            best_c = c;
         end
      end
      if (best_f == 0) begin
         best_s = 0;
         best_c = 0;
      end
      res.found          = (best_f > 0);
      res.best_start     = 4'(best_s);
      res.field_count    = 4'(best_f);
      res.consumed_bytes = 16'(best_c);
      res.too_long       = (scan_pos > 17'(pbws_pkg::MAX_PAYLOAD));
      expected_scans.push_back(res);
      clear_lanes();
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string what);
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      fail_count++;
   endtask

   // every result transfer is compared against the oldest pending scan
   always @(posedge clock) begin
      pbws_pkg::pbws_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_scans.size() == 0) begin
            report_mismatch("result with nothing pending");
         end else begin
            want = expected_scans.pop_front();
            if (rsp_payload.found !== want.found)
               report_mismatch($sformatf("found %0b want %0b",
                  rsp_payload.found, want.found));
            if (rsp_payload.best_start !== want.best_start)
               report_mismatch($sformatf("best_start %0d want %0d",
                  rsp_payload.best_start, want.best_start));
            if (rsp_payload.field_count !== want.field_count)
               report_mismatch($sformatf("field_count %0d want %0d",
                  rsp_payload.field_count, want.field_count));
            if (rsp_payload.consumed_bytes !== want.consumed_bytes)
               report_mismatch($sformatf("consumed_bytes %0d want %0d",
                  rsp_payload.consumed_bytes, want.consumed_bytes));
            if (rsp_payload.too_long !== want.too_long)
               report_mismatch($sformatf("too_long %0b want %0b",
                  rsp_payload.too_long, want.too_long));
         end
      end
   end

   // receiver stalls: a free-flowing stretch, then random back pressure, in turn
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count[8:7] == 2'd0)
         rsp_ready <= 1'b1;
      else if (cycle_count[8:7] == 2'd1)
         rsp_ready <= ($urandom_range(0, 3) != 0);
      else
         rsp_ready <= ($urandom_range(0, 1) != 0);
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("protobuf_wire_candidate_scanner_core verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- driving

   // one byte transfer; gaps between bursts when pacing is on
   task automatic send_byte(logic [7:0] b, logic last);
      int gap;
      if (pacing_on && burst_left == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 16);
      end
      if (burst_left > 0) burst_left--;
      req_valid               <= 1'b1;
      req_payload.byte_value  <= b;
      req_payload.last_byte   <= last;
      do @(posedge clock); while (!req_ready);
      scan_byte(b, last);
   endtask

   task automatic send_payload(byte unsigned bytes[$]);
      for (int i = 0; i < bytes.size(); i++)
         send_byte(bytes[i], i == bytes.size() - 1);
   endtask

   // idle the sender until every pending scan result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_scans.size() != 0) @(posedge clock);
   endtask

   task automatic write_field_limit(logic [15:0] value);
      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      field_limit = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------- payload building

   function automatic void push_varint(ref byte unsigned q[$], input logic [63:0] v);
      logic [7:0] b;
      do begin
         b = {1'b0, v[6:0]};
         v = v >> 7;
         if (v != 0) b[7] = 1'b1;
         q.push_back(b);
      end while (v != 0);
   endfunction

   function automatic logic [63:0] random_value();
      return {$urandom, $urandom} >> $urandom_range(0, 63);
   endfunction

   // picks a field number: mostly small and legal, sometimes on or past the limit
   function automatic logic [63:0] pick_field_number();
      case ($urandom_range(0, 11))
         0: return 64'(field_limit);
         1: return 64'(field_limit) + 1;
         2: return 0;
         3: return 64'($urandom_range(1, 65535));
         4: return 64'(1) << $urandom_range(21, 60);   // key overflows the window
         default: return 64'($urandom_range(1, 15));
      endcase
   endfunction

   // a stream of fields with random content, some malformed
   function automatic void build_message(ref byte unsigned q[$], input int nfields);
      logic [2:0]  wt;
      int          len, r;
      for (int f = 0; f < nfields; f++) begin
         r = $urandom_range(0, 19);
         if (r < 7) wt = pbws_pkg::WIRE_VARINT;
         else if (r < 10) wt = pbws_pkg::WIRE_FIXED64;
         else if (r < 15) wt = pbws_pkg::WIRE_LEN;
         else if (r < 18) wt = pbws_pkg::WIRE_FIXED32;
         else wt = 3'($urandom_range(3, 7));
         push_varint(q, (pick_field_number() << 3) | 64'(wt));
         case (wt)
            pbws_pkg::WIRE_VARINT: push_varint(q, random_value());
            pbws_pkg::WIRE_FIXED64: repeat (8) q.push_back(8'($urandom));
            pbws_pkg::WIRE_FIXED32: repeat (4) q.push_back(8'($urandom));
            pbws_pkg::WIRE_LEN: begin
               if ($urandom_range(0, 15) == 0) begin
                  push_varint(q, random_value());          // usually hopeless
               end else begin
                  len = $urandom_range(0, 6);
                  push_varint(q, 64'(len));
                  repeat (len) q.push_back(8'($urandom));
               end
            end
            default: ;
         endcase
      end
   endfunction

   // ---------------------------------------------------------------- tests

   // extremes of the byte, wire type rejects, long varints, huge lengths, field cap
   task automatic test_directed();
      send_payload('{8'hFF});                                       // lone byte, no field
      send_payload('{8'h00, 8'h08, 8'h00});                         // field zero at offset 0
      send_payload('{8'h08, 8'h96, 8'h01, 8'h15, 8'h01, 8'h02, 8'h03, 8'h04});
      send_payload('{8'h0B, 8'h0C, 8'h0E, 8'h0F, 8'h09,             // group and bad wires
                     8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08});
      // ten-byte varint with the top bit set, then an eleven-byte varint
      send_payload('{8'h08, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                     8'hFF, 8'hFF, 8'h7F, 8'h08,
                     8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
                     8'h80, 8'h80, 8'h00});
      // a zero body, then a length past the payload bound
      send_payload('{8'h12, 8'h00, 8'h12, 8'h80, 8'h80, 8'h04, 8'h01, 8'h02});
      // more fields than a lane will count
      begin
         byte unsigned q[$];
         repeat (14) begin
            q.push_back(8'h08);
            q.push_back(8'h00);
         end
         send_payload(q);
      end
   endtask

   // a sweep of limits, the extremes included
   task automatic test_field_limits();
      logic [15:0] limits[6] = '{16'd0, 16'd1, 16'd15, 16'd65535, 16'd300, 16'd4096};
      byte unsigned q[$];
      foreach (limits[i]) begin
         write_field_limit(limits[i]);
         repeat (4) begin
            q.delete();
            build_message(q, $urandom_range(1, 6));
            send_payload(q);
         end
      end
   endtask

   // mostly well formed payloads, with junk in front, cut-offs and noise
   task automatic test_random_payloads(int byte_budget);
      byte unsigned q[$];
      int           sent;
      int           r;
      bit           paused;
      sent   = 0;
      paused = 0;
      while (sent < byte_budget) begin
         q.delete();
         r = $urandom_range(0, 19);
         if (r < 2) begin
            repeat ($urandom_range(1, 30)) q.push_back(8'($urandom));
         end else begin
            if ($urandom_range(0, 2) == 0)
               repeat ($urandom_range(1, LANES - 1)) q.push_back(8'($urandom));
            build_message(q, $urandom_range(1, 14));
            if (r < 5 && q.size() > 1)
               repeat ($urandom_range(1, q.size() - 1)) void'(q.pop_back());
         end
         // sender rests sometimes, and one long stretch runs without gaps
         pacing_on = !(sent > byte_budget / 3 && sent < byte_budget / 2);
         send_payload(q);
         sent += q.size();
         if (!paused && sent > byte_budget / 2) begin
            wait_drained();
            paused = 1;
         end
      end
      pacing_on = 1;
   endtask

   initial begin
      fail_count   = 0;
      pacing_on    = 1;
      burst_left   = 0;
      field_limit  = 16'(pbws_pkg::FIELD_LIMIT_RESET);
      clear_lanes();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_field_limits();
      write_field_limit(16'(pbws_pkg::FIELD_LIMIT_RESET));
      test_random_payloads(480);
      write_field_limit(16'($urandom_range(16, 2000)));
      test_random_payloads(200);

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0)
         $display("protobuf_wire_candidate_scanner_core verification clean");
      else
         $display("protobuf_wire_candidate_scanner_core verification failed");
      $finish;
   end

endmodule
`default_nettype wire
